FILE: src/jdce_pkg.sv
// Shared types, command codes and arithmetic helpers for the joystick drive encoder.
// Used by every module in src; depends on nothing.
`default_nettype none

package jdce_pkg;

  localparam int unsigned AXIS_FULL_SCALE = 32767;
  localparam int unsigned SPEED_SCALE = 255;
  localparam int unsigned SERVO_SCALE = 127;
  localparam logic [7:0] SERVO_CENTRE = 8'd128;

  localparam logic [7:0] CODE_STOP = 8'h20;
  localparam logic [7:0] CODE_FWD = 8'h77;
  localparam logic [7:0] CODE_BACK = 8'h73;
  localparam logic [7:0] CODE_LEFT = 8'h61;
  localparam logic [7:0] CODE_RIGHT = 8'h64;
  localparam logic [7:0] CODE_PAN = 8'h50;
  localparam logic [7:0] CODE_TILT = 8'h54;
  localparam logic [7:0] CODE_RANGE = 8'h55;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] CFG_CENTRE_BAND = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_SPEED = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_INVERT_PAN = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_INVERT_TILT = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_REQ_MASK = 3'd4;

  localparam int unsigned MSG_RANGE = 0;
  localparam int unsigned MSG_DRIVE = 1;
  localparam int unsigned MSG_PAN = 2;
  localparam int unsigned MSG_TILT = 3;

  typedef struct packed {
    logic [14:0] centre_band;
    logic [7:0]  min_speed;
    logic        invert_pan;
    logic        invert_tilt;
    logic [15:0] req_mask;
  } cfg_t;

  typedef struct packed {
    logic [3:0] mask;
    logic [7:0] drive_code;
    logic [7:0] drive_speed;
    logic [7:0] pan;
    logic [7:0] tilt;
  } bundle_t;

  // Magnitude of a 16-bit two's complement value; the most negative value gives 32768.
  function automatic logic [16:0] abs16(input logic [15:0] v);
    logic [16:0] e;
    e = {v[15], v};
    return v[15] ? (~e + 17'd1) : e;
  endfunction

  // Quotient by 32767 for products below 256 * 32767, using 2^15 = 32767 + 1.
  function automatic logic [7:0] div_fs(input logic [22:0] p);
    logic [7:0]  q0;
    logic [15:0] r;
    q0 = p[22:15];
    r = {1'b0, p[14:0]} + {8'd0, q0};
    return (r >= 16'(AXIS_FULL_SCALE)) ? (q0 + 8'd1) : q0;
  endfunction

endpackage

`default_nettype wire

FILE: src/jdce_front.sv
// Front end of the joystick drive encoder: input register, scaling stage and the
// decision stage that compares against the last sent values. Depends on jdce_pkg.
`default_nettype none

module jdce_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire jdce_pkg::cfg_t        cfg_i,
  input  wire logic                  push_i,
  output logic                       full_o,
  input  wire logic signed [15:0]    left_x_i,
  input  wire logic signed [15:0]    left_y_i,
  input  wire logic signed [15:0]    right_x_i,
  input  wire logic signed [15:0]    right_y_i,
  input  wire logic [15:0]           button_word_i,
  input  wire logic                  pad_present_i,
  output logic                       q_push_o,
  input  wire logic                  q_full_i,
  output jdce_pkg::bundle_t          q_data_o
);

  typedef struct packed {
    logic [7:0]  code;
    logic        spd_zero;
    logic [22:0] spd_prod;
    logic        pan_dz;
    logic        pan_neg;
    logic [21:0] pan_prod;
    logic        tilt_dz;
    logic        tilt_neg;
    logic [21:0] tilt_prod;
    logic [15:0] buttons;
    logic        present;
  } scaled_t;

  logic        s0_v_q;
  logic [15:0] lx_q, ly_q, rx_q, ry_q, btn_q;
  logic        present_q;
  logic        s1_v_q;
  scaled_t     s1_q, s1_d;

  logic        s1_adv, s1_free, s0_adv, s0_free, accept;

  logic [7:0]  sent_code_q, sent_code_d;
  logic [7:0]  sent_spd_q, sent_spd_d;
  logic [7:0]  sent_pan_q, sent_pan_d;
  logic [7:0]  sent_tilt_q, sent_tilt_d;
  logic [15:0] prev_btn_q, prev_btn_d;

  assign accept = push_i && !full_o;
  assign s1_adv = s1_v_q && !q_full_i;
  assign s1_free = !s1_v_q || s1_adv;
  assign s0_adv = s0_v_q && s1_free;
  assign s0_free = !s0_v_q || s0_adv;
  assign full_o = !s0_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
    end else begin
      if (s0_free) begin
        s0_v_q <= push_i;
      end
      if (s1_free) begin
        s1_v_q <= s0_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lx_q <= left_x_i;
      ly_q <= left_y_i;
      rx_q <= right_x_i;
      ry_q <= right_y_i;
      btn_q <= button_word_i;
      present_q <= pad_present_i;
    end
    if (s0_adv) begin
      s1_q <= s1_d;
    end
  end

  // Scaling stage: pick the dominant axis and form the products.
  logic [16:0] alx, aly, arx, ary, dz, a_sel;
  logic [14:0] a_sat, rx_sat, ry_sat;
  logic        vert;

  always_comb begin
    dz = {2'b00, cfg_i.centre_band};
    alx = jdce_pkg::abs16(lx_q);
    aly = jdce_pkg::abs16(ly_q);
    arx = jdce_pkg::abs16(rx_q);
    ary = jdce_pkg::abs16(ry_q);
    vert = (aly >= alx);
    a_sel = vert ? aly : alx;
    a_sat = a_sel[15] ? 15'(jdce_pkg::AXIS_FULL_SCALE) : a_sel[14:0];
    rx_sat = arx[15] ? 15'(jdce_pkg::AXIS_FULL_SCALE) : arx[14:0];
    ry_sat = ary[15] ? 15'(jdce_pkg::AXIS_FULL_SCALE) : ary[14:0];

    s1_d.buttons = btn_q;
    s1_d.present = present_q;
    if (alx < dz && aly < dz) begin
      s1_d.code = jdce_pkg::CODE_STOP;
      s1_d.spd_zero = 1'b1;
    end else if (vert) begin
      s1_d.code = (!ly_q[15] && ly_q != 16'd0) ? jdce_pkg::CODE_FWD : jdce_pkg::CODE_BACK;
      s1_d.spd_zero = (a_sel < dz);
    end else begin
      s1_d.code = lx_q[15] ? jdce_pkg::CODE_LEFT : jdce_pkg::CODE_RIGHT;
      s1_d.spd_zero = (a_sel < dz);
    end
    s1_d.spd_prod = 23'(a_sat) * 23'(jdce_pkg::SPEED_SCALE);
    s1_d.pan_dz = (arx < dz);
    s1_d.pan_neg = rx_q[15] ^ cfg_i.invert_pan;
    s1_d.pan_prod = 22'(rx_sat) * 22'(jdce_pkg::SERVO_SCALE);
    s1_d.tilt_dz = (ary < dz);
    s1_d.tilt_neg = ry_q[15] ^ cfg_i.invert_tilt;
    s1_d.tilt_prod = 22'(ry_sat) * 22'(jdce_pkg::SERVO_SCALE);
  end

  // Decision stage: finish the scaling and compare against the last sent values.
  logic [7:0] spd_q8, pan_q8, tilt_q8, spd, code, pan, tilt;
  logic       range_edge;

  always_comb begin
    spd_q8 = jdce_pkg::div_fs(s1_q.spd_prod);
    pan_q8 = jdce_pkg::div_fs({1'b0, s1_q.pan_prod});
    tilt_q8 = jdce_pkg::div_fs({1'b0, s1_q.tilt_prod});

    spd = s1_q.spd_zero ? 8'd0 : spd_q8;
    code = s1_q.code;
    if (spd < cfg_i.min_speed) begin
      code = jdce_pkg::CODE_STOP;
      spd = 8'd0;
    end

    if (s1_q.pan_dz) begin
      pan = jdce_pkg::SERVO_CENTRE;
    end else if (s1_q.pan_neg) begin
      pan = jdce_pkg::SERVO_CENTRE - pan_q8;
    end else begin
      pan = jdce_pkg::SERVO_CENTRE + pan_q8;
    end
    if (s1_q.tilt_dz) begin
      tilt = jdce_pkg::SERVO_CENTRE;
    end else if (s1_q.tilt_neg) begin
      tilt = jdce_pkg::SERVO_CENTRE - tilt_q8;
    end else begin
      tilt = jdce_pkg::SERVO_CENTRE + tilt_q8;
    end

    range_edge = ((s1_q.buttons & cfg_i.req_mask) != 16'd0) &&
                 ((prev_btn_q & cfg_i.req_mask) == 16'd0);

    q_data_o.mask = 4'd0;
    q_data_o.drive_code = code;
    q_data_o.drive_speed = spd;
    q_data_o.pan = pan;
    q_data_o.tilt = tilt;
    sent_code_d = sent_code_q;
    sent_spd_d = sent_spd_q;
    sent_pan_d = sent_pan_q;
    sent_tilt_d = sent_tilt_q;
    prev_btn_d = prev_btn_q;

    if (!s1_q.present) begin
      q_data_o.drive_code = jdce_pkg::CODE_STOP;
      q_data_o.drive_speed = 8'd0;
      q_data_o.mask[jdce_pkg::MSG_DRIVE] = (sent_code_q != jdce_pkg::CODE_STOP);
      sent_code_d = jdce_pkg::CODE_STOP;
      sent_spd_d = 8'd0;
    end else begin
      q_data_o.mask[jdce_pkg::MSG_RANGE] = range_edge;
      q_data_o.mask[jdce_pkg::MSG_DRIVE] = (code != sent_code_q) || (spd != sent_spd_q);
      q_data_o.mask[jdce_pkg::MSG_PAN] = (pan != sent_pan_q);
      q_data_o.mask[jdce_pkg::MSG_TILT] = (tilt != sent_tilt_q);
      prev_btn_d = s1_q.buttons;
      sent_code_d = code;
      sent_spd_d = spd;
      sent_pan_d = pan;
      sent_tilt_d = tilt;
    end
  end

  assign q_push_o = s1_adv && (q_data_o.mask != 4'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_code_q <= jdce_pkg::CODE_STOP;
      sent_spd_q <= 8'd0;
      sent_pan_q <= jdce_pkg::SERVO_CENTRE;
      sent_tilt_q <= jdce_pkg::SERVO_CENTRE;
      prev_btn_q <= 16'd0;
    end else if (s1_adv) begin
      sent_code_q <= sent_code_d;
      sent_spd_q <= sent_spd_d;
      sent_pan_q <= sent_pan_d;
      sent_tilt_q <= sent_tilt_d;
      prev_btn_q <= prev_btn_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/jdce_queue.sv
// Short first-in first-out queue of message bundles between the front and back ends.
// Depends on jdce_pkg for the bundle type.
`default_nettype none

module jdce_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  output logic                    full_o,
  input  wire jdce_pkg::bundle_t  data_i,
  input  wire logic               pop_i,
  output logic                    empty_o,
  output jdce_pkg::bundle_t       data_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  jdce_pkg::bundle_t mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              do_push, do_pop;

  assign full_o = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/jdce_back.sv
// Back end of the joystick drive encoder: walks each bundle and sends one word a cycle
// through the output register while it is free or being popped. Depends on jdce_pkg.
`default_nettype none

module jdce_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_empty_i,
  input  wire jdce_pkg::bundle_t  q_data_i,
  output logic                    q_pop_o,
  output logic                    empty_o,
  input  wire logic               pop_i,
  output logic [7:0]              command_code_o,
  output logic [7:0]              command_value_o,
  output logic                    value_present_o,
  output logic                    last_message_o
);

  jdce_pkg::bundle_t cur_q;
  logic [3:0]        rem_q, rem_d, sel, rem_after;
  logic              out_v_q, out_free, emit, load;
  logic [7:0]        code_d, value_d;
  logic              present_d;

  assign out_free = !out_v_q || pop_i;
  assign emit = (rem_q != 4'd0) && out_free;
  assign sel = rem_q & (~rem_q + 4'd1);
  assign rem_after = rem_q & ~sel;
  assign load = (rem_q == 4'd0) || (emit && rem_after == 4'd0);
  assign q_pop_o = load && !q_empty_i;
  assign empty_o = !out_v_q;

  always_comb begin
    if (q_pop_o) begin
      rem_d = q_data_i.mask;
    end else if (emit) begin
      rem_d = rem_after;
    end else begin
      rem_d = rem_q;
    end

    code_d = jdce_pkg::CODE_TILT;
    value_d = cur_q.tilt;
    present_d = 1'b1;
    if (sel[jdce_pkg::MSG_RANGE]) begin
      code_d = jdce_pkg::CODE_RANGE;
      value_d = 8'd0;
      present_d = 1'b0;
    end else if (sel[jdce_pkg::MSG_DRIVE]) begin
      code_d = cur_q.drive_code;
      present_d = (cur_q.drive_code != jdce_pkg::CODE_STOP);
      value_d = present_d ? cur_q.drive_speed : 8'd0;
    end else if (sel[jdce_pkg::MSG_PAN]) begin
      code_d = jdce_pkg::CODE_PAN;
      value_d = cur_q.pan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 4'd0;
      out_v_q <= 1'b0;
    end else begin
      rem_q <= rem_d;
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (pop_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_data_i;
    end
    if (emit) begin
      command_code_o <= code_d;
      command_value_o <= value_d;
      value_present_o <= present_d;
      last_message_o <= (rem_after == 4'd0);
    end
  end

endmodule

`default_nettype wire

FILE: src/joystick_to_drive_command_encoder.sv
// A sample's first word passes the input register, the scaling register, the queue, the back
// end's bundle register and the output register. One sample a cycle is accepted while full is
// low; words leave at one a cycle while pop keeps the output free, and a sample causes at most
// 4 words. Reset clears all control state, the last sent values and the configuration
// registers to their defaults. Depends on jdce_pkg, jdce_front, jdce_queue and jdce_back.
`default_nettype none

module joystick_to_drive_command_encoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [jdce_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  wire logic [jdce_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic signed [15:0]                  left_x_i,
  input  wire logic signed [15:0]                  left_y_i,
  input  wire logic signed [15:0]                  right_x_i,
  input  wire logic signed [15:0]                  right_y_i,
  input  wire logic [15:0]                         button_word_i,
  input  wire logic                                pad_present_i,
  output logic                                     empty,
  input  wire logic                                pop,
  output logic [7:0]                               command_code_o,
  output logic [7:0]                               command_value_o,
  output logic                                     value_present_o,
  output logic                                     last_message_o
);

  jdce_pkg::cfg_t    cfg_q;
  jdce_pkg::bundle_t push_data, head_data;
  logic              q_push, q_full, q_pop, q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.centre_band <= 15'd8000;
      cfg_q.min_speed <= 8'd3;
      cfg_q.invert_pan <= 1'b0;
      cfg_q.invert_tilt <= 1'b1;
      cfg_q.req_mask <= 16'h4000;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        jdce_pkg::CFG_CENTRE_BAND: begin
          cfg_q.centre_band <= cfg_data_i[14:0];
        end
        jdce_pkg::CFG_MIN_SPEED: begin
          cfg_q.min_speed <= cfg_data_i[7:0];
        end
        jdce_pkg::CFG_INVERT_PAN: begin
          cfg_q.invert_pan <= cfg_data_i[0];
        end
        jdce_pkg::CFG_INVERT_TILT: begin
          cfg_q.invert_tilt <= cfg_data_i[0];
        end
        jdce_pkg::CFG_REQ_MASK: begin
          cfg_q.req_mask <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  jdce_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .push_i        (push),
    .full_o        (full),
    .left_x_i      (left_x_i),
    .left_y_i      (left_y_i),
    .right_x_i     (right_x_i),
    .right_y_i     (right_y_i),
    .button_word_i (button_word_i),
    .pad_present_i (pad_present_i),
    .q_push_o      (q_push),
    .q_full_i      (q_full),
    .q_data_o      (push_data)
  );

  jdce_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .full_o  (q_full),
    .data_i  (push_data),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (head_data)
  );

  jdce_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_data_i        (head_data),
    .q_pop_o         (q_pop),
    .empty_o         (empty),
    .pop_i           (pop),
    .command_code_o  (command_code_o),
    .command_value_o (command_value_o),
    .value_present_o (value_present_o),
    .last_message_o  (last_message_o)
  );

endmodule

`default_nettype wire
